// ===== design/bom_sniffing_utf_to_utf8_transcoder_unit_defines.svh =====
// Assertion macros for the transcoder.
// Each macro expects aclk and aresetn in scope.
`ifndef BOM_SNIFFING_UTF_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define BOM_SNIFFING_UTF_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond holds at every edge out of reset
`define BSU8_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("transcoder check failed");

// pre in a cycle implies post in the same cycle
`define BSU8_ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("transcoder check failed");

// pre in a cycle implies post in the next cycle
`define BSU8_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("transcoder check failed");

`else

`define BSU8_ASSERT_ALWAYS(label, cond)
`define BSU8_ASSERT_IMPLIES(label, pre, post)
`define BSU8_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== design/bsu8_pkg.sv =====
`default_nettype none

package bsu8_pkg;

    // encoding codes; MODE_UNDET only lives in the decoder state
    localparam logic [2:0] ENC_UTF8     = 3'd0;
    localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
    localparam logic [2:0] ENC_UTF16LE  = 3'd2;
    localparam logic [2:0] ENC_UTF16BE  = 3'd3;
    localparam logic [2:0] ENC_UTF32LE  = 3'd4;
    localparam logic [2:0] ENC_UTF32BE  = 3'd5;
    localparam logic [2:0] MODE_UNDET   = 3'd7;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_ODD32    = 4'd1;
    localparam logic [3:0] ST_ODD16    = 4'd2;
    localparam logic [3:0] ST_RANGE    = 4'd3;
    localparam logic [3:0] ST_HS_END   = 4'd4;
    localparam logic [3:0] ST_BAD_LOW  = 4'd5;
    localparam logic [3:0] ST_LONE_LOW = 4'd6;
    localparam logic [3:0] ST_NONCHAR  = 4'd7;
    localparam logic [3:0] ST_NONASCII = 4'd8;

    localparam int MaxResults = 8;

    localparam logic [15:0] HS_FIRST = 16'hD800;
    localparam logic [15:0] HS_LAST  = 16'hDBFF;
    localparam logic [15:0] LS_FIRST = 16'hDC00;
    localparam logic [15:0] LS_LAST  = 16'hDFFF;
    localparam logic [15:0] PAIR_OFS = 16'hD7C0;
    localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] unit_asm;
        logic [1:0]  pos;
        logic [15:0] hs;
        logic        pend;
        logic        halt;
    } dec_state_t;

    localparam dec_state_t DEC_RESET = '{
        mode: MODE_UNDET, unit_asm: 24'h0, pos: 2'd0, hs: 16'h0, pend: 1'b0, halt: 1'b0
    };

    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [3:0]                 cnt;
        logic [3:0]                 status;
    } res_list_t;

    typedef struct packed {
        dec_state_t st;
        res_list_t  res;
    } dec_ctx_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] skip;
        logic       nonascii;
    } det_t;

    function automatic dec_ctx_t put_byte(dec_ctx_t c, logic [7:0] b);
        dec_ctx_t r;
        r = c;
        if (c.res.cnt < 4'(MaxResults)) begin
            r.res.bytes[c.res.cnt[2:0]] = b;
            r.res.cnt = c.res.cnt + 4'd1;
        end
        return r;
    endfunction

    function automatic dec_ctx_t fail_code(dec_ctx_t c, logic [3:0] code);
        dec_ctx_t r;
        r = put_byte(c, 8'h00);
        r.res.status = code;
        r.st.halt = 1'b1;
        return r;
    endfunction

    function automatic dec_ctx_t emit_cp(dec_ctx_t c, logic [20:0] cp);
        dec_ctx_t r;
        r = c;
        if (cp < 21'h80) begin
            r = put_byte(r, cp[7:0]);
        end else if (cp < 21'h800) begin
            r = put_byte(r, {3'b110, cp[10:6]});
            r = put_byte(r, {2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            r = put_byte(r, {4'b1110, cp[15:12]});
            r = put_byte(r, {2'b10, cp[11:6]});
            r = put_byte(r, {2'b10, cp[5:0]});
        end else begin
            r = put_byte(r, {5'b11110, cp[20:18]});
            r = put_byte(r, {2'b10, cp[17:12]});
            r = put_byte(r, {2'b10, cp[11:6]});
            r = put_byte(r, {2'b10, cp[5:0]});
        end
        return r;
    endfunction

    function automatic dec_ctx_t unit16(dec_ctx_t c, logic [15:0] u);
        dec_ctx_t    r;
        logic [15:0] hs_ofs;
        logic [15:0] lo_ofs;
        r = c;
        hs_ofs = c.st.hs - PAIR_OFS;
        lo_ofs = u - LS_FIRST;
        if (c.st.pend) begin
            r.st.pend = 1'b0;
            if (u < LS_FIRST || u > LS_LAST) begin
                r = fail_code(r, ST_BAD_LOW);
            end else begin
                r = emit_cp(r, {hs_ofs[10:0], lo_ofs[9:0]});
            end
        end else if (u >= HS_FIRST && u <= HS_LAST) begin
            r.st.hs = u;
            r.st.pend = 1'b1;
        end else if (u >= LS_FIRST && u <= LS_LAST) begin
            r = fail_code(r, ST_LONE_LOW);
        end else if (u == 16'hFFFE || u == 16'hFFFF) begin
            r = fail_code(r, ST_NONCHAR);
        end else begin
            r = emit_cp(r, {5'd0, u});
        end
        return r;
    endfunction

    function automatic dec_ctx_t feed(dec_ctx_t c, logic [7:0] b);
        dec_ctx_t    r;
        logic        le;
        logic [15:0] u;
        logic [31:0] v;
        r = c;
        le = (c.st.mode == ENC_UTF16LE) || (c.st.mode == ENC_UTF32LE);
        u = '0;
        v = '0;
        if (!c.st.halt) begin
            if (c.st.mode == ENC_UTF16LE || c.st.mode == ENC_UTF16BE) begin
                if (c.st.pos == 2'd0) begin
                    r.st.unit_asm = {16'h0, b};
                    r.st.pos = 2'd1;
                end else begin
                    u = le ? {b, c.st.unit_asm[7:0]} : {c.st.unit_asm[7:0], b};
                    r.st.unit_asm = 24'h0;
                    r.st.pos = 2'd0;
                    r = unit16(r, u);
                end
            end else if (c.st.mode == ENC_UTF32LE || c.st.mode == ENC_UTF32BE) begin
                if (c.st.pos != 2'd3) begin
                    if (le) begin
                        r.st.unit_asm = c.st.unit_asm | (24'(b) << {c.st.pos, 3'b000});
                    end else begin
                        r.st.unit_asm = {c.st.unit_asm[15:0], b};
                    end
                    r.st.pos = c.st.pos + 2'd1;
                end else begin
                    v = le ? {b, c.st.unit_asm} : {c.st.unit_asm, b};
                    r.st.unit_asm = 24'h0;
                    r.st.pos = 2'd0;
                    if (v > CP_MAX) begin
                        r = fail_code(r, ST_RANGE);
                    end else begin
                        r = emit_cp(r, v[20:0]);
                    end
                end
            end else begin
                r = put_byte(r, b);
            end
        end
        return r;
    endfunction

    // BOM check first, then zero-byte pattern of the first character, else UTF-8 (non-ASCII first byte flagged)
    function automatic det_t detect(logic [3:0][7:0] hb, logic [2:0] n);
        det_t       d;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] h3;
        d  = '0;
        h0 = hb[0];
        h1 = hb[1];
        h2 = (n >= 3'd3) ? hb[2] : 8'h00;
        h3 = (n >= 3'd4) ? hb[3] : 8'h00;
        priority if (h0 == 8'hFF && h1 == 8'hFE) begin
            if (n >= 3'd4 && h2 == 8'h00 && h3 == 8'h00) begin
                d.mode = ENC_UTF32LE;
                d.skip = 3'd4;
            end else begin
                d.mode = ENC_UTF16LE;
                d.skip = 3'd2;
            end
        end else if (h0 == 8'hFE && h1 == 8'hFF) begin
            d.mode = ENC_UTF16BE;
            d.skip = 3'd2;
        end else if (n >= 3'd4 && h0 == 8'h00 && h1 == 8'h00
                     && h2 == 8'hFE && h3 == 8'hFF) begin
            d.mode = ENC_UTF32BE;
            d.skip = 3'd4;
        end else if (n >= 3'd3 && h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF) begin
            d.mode = ENC_UTF8_BOM;
            d.skip = 3'd3;
        end else if (n >= 3'd4 && h1 == 8'h00 && h2 == 8'h00 && h3 == 8'h00) begin
            d.mode = ENC_UTF32LE;
        end else if (n >= 3'd4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'h00) begin
            d.mode = ENC_UTF32BE;
        end else if (h1 == 8'h00) begin
            d.mode = ENC_UTF16LE;
        end else if (h0 == 8'h00) begin
            d.mode = ENC_UTF16BE;
        end else begin
            d.mode = ENC_UTF8;
            d.nonascii = h0[7];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/bom_sniffing_utf_to_utf8_transcoder_unit.sv =====
// Text transcoder: raw file bytes in, UTF-8 bytes out.
// Slave channel: one item per source byte, s_tlast on the final byte of a file.
// Master channel: UTF-8 bytes; m_tuser carries status and detected encoding,
// m_tdata[8] flags the last byte made from one source byte, m_tlast the last
// byte of the file. An error gives one item with byte 0 and a status code,
// after which the rest of the file is dropped; the last byte re-arms the block.
// A source byte passes from the input register to the result register.
// The first three bytes of a file give nothing while the encoding is sniffed;
// the fourth (or the last) flushes them in one go.
// Throughput: one source byte per cycle while m_tready is high and each byte
// yields at most one result; a byte that yields more holds the input until the
// 8-entry result shift register (one item out per cycle with m_tready high) is on its last item.
// Stalls: m_tready low freezes the result register; one source byte waits in
// the input register, then s_tready drops.
// Reset: synchronous, aresetn low; both registers empty, decoder re-armed.
`default_nettype none

`include "bom_sniffing_utf_to_utf8_transcoder_unit_defines.svh"

module bom_sniffing_utf_to_utf8_transcoder_unit
    import bsu8_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] last_of_run, rest zero
    output logic [6:0]       m_tuser,   // [3:0] status, [6:4] encoding
    output logic             m_tlast    // end_of_text
);

    localparam logic [3:0] RES_CNT_MAX = 4'(MaxResults);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // decoder state
    logic [3:0][7:0] hdr_reg;
    logic [3:0][7:0] hdr_next;
    logic [2:0]      hdr_cnt_reg;
    logic [2:0]      hdr_cnt_next;
    dec_state_t      st_reg;
    dec_state_t      st_next;

    // result shift register, head at entry 0
    logic [MaxResults-1:0][7:0] res_byte_reg;
    logic [3:0]                 res_cnt_reg;
    logic [3:0]                 res_stat_reg;
    logic [2:0]                 res_enc_reg;
    logic                       res_eot_reg;

    // per-item decode
    dec_ctx_t        ctx;
    logic [3:0][7:0] hb;
    logic [2:0]      hcnt_inc;
    det_t            det;
    logic [2:0]      enc_next;

    logic res_free;
    logic load;
    logic take;

    assign take     = m_tvalid && m_tready;
    assign res_free = (res_cnt_reg == 4'd0) || ((res_cnt_reg == 4'd1) && m_tready);
    assign load     = in_valid_reg && res_free;
    assign s_tready = !in_valid_reg || res_free;

    assign m_tvalid = (res_cnt_reg != 4'd0);
    assign m_tdata  = {7'd0, (res_cnt_reg == 4'd1), res_byte_reg[0]};
    assign m_tuser  = {res_enc_reg, (res_cnt_reg == 4'd1) ? res_stat_reg : ST_OK};
    assign m_tlast  = (res_cnt_reg == 4'd1) && res_eot_reg;

    // whole decode of one item: header sniff, up to four byte feeds, end checks
    always_comb begin
        ctx.st       = st_reg;
        ctx.res      = '0;
        hb           = hdr_reg;
        hdr_next     = hdr_reg;
        hdr_cnt_next = hdr_cnt_reg;
        hcnt_inc     = hdr_cnt_reg + 3'd1;
        det          = '0;

        if (st_reg.halt) begin
            // dropping until end of file
        end else if (st_reg.mode == MODE_UNDET) begin
            hb[hdr_cnt_reg[1:0]] = in_byte_reg;
            hdr_next             = hb;
            hdr_cnt_next         = hcnt_inc;
            if (hcnt_inc < 3'd4 && !in_last_reg) begin
                // still collecting the header
            end else if (hcnt_inc < 3'd2) begin
                // one-byte file goes through untouched
                ctx.st.mode = ENC_UTF8;
                ctx = put_byte(ctx, in_byte_reg);
            end else begin
                det = detect(hb, hcnt_inc);
                ctx.st.mode = det.mode;
                if (det.nonascii) begin
                    ctx = fail_code(ctx, ST_NONASCII);
                end
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) >= det.skip && 3'(i) < hcnt_inc) begin
                        ctx = feed(ctx, hb[i]);
                    end
                end
            end
        end else begin
            ctx = feed(ctx, in_byte_reg);
        end

        // end of file: partial unit or dangling high surrogate
        if (in_last_reg && !ctx.st.halt) begin
            if (ctx.st.pos != 2'd0) begin
                ctx = fail_code(ctx,
                    (ctx.st.mode == ENC_UTF32LE || ctx.st.mode == ENC_UTF32BE) ?
                    ST_ODD32 : ST_ODD16);
            end else if (ctx.st.pend) begin
                ctx = fail_code(ctx, ST_HS_END);
            end
        end

        enc_next = (ctx.st.mode == MODE_UNDET) ? ENC_UTF8 : ctx.st.mode;

        st_next = ctx.st;
        if (in_last_reg) begin
            st_next      = DEC_RESET;
            hdr_cnt_next = 3'd0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            res_cnt_reg  <= 4'd0;
            hdr_cnt_reg  <= 3'd0;
            st_reg       <= DEC_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end

            if (load) begin
                res_cnt_reg <= ctx.res.cnt;
                hdr_cnt_reg <= hdr_cnt_next;
                st_reg      <= st_next;
            end else if (take) begin
                res_cnt_reg <= res_cnt_reg - 4'd1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (load) begin
            hdr_reg      <= hdr_next;
            res_byte_reg <= ctx.res.bytes;
            res_stat_reg <= ctx.res.status;
            res_enc_reg  <= enc_next;
            res_eot_reg  <= in_last_reg;
        end else if (take) begin
            res_byte_reg <= {8'h00, res_byte_reg[MaxResults-1:1]};
        end
    end

    `BSU8_ASSERT_ALWAYS(a_res_cnt_bound, res_cnt_reg <= RES_CNT_MAX)
    `BSU8_ASSERT_IMPLIES(a_err_is_final, m_tvalid && (m_tuser[3:0] != ST_OK), m_tdata[8] && (m_tdata[7:0] == 8'h00))
    `BSU8_ASSERT_IMPLIES(a_eot_ends_run, m_tvalid && m_tlast, m_tdata[8])
    `BSU8_ASSERT_NEXT(a_rearm_on_last, load && in_last_reg, (st_reg.mode == MODE_UNDET) && !st_reg.halt && (hdr_cnt_reg == 3'd0))

endmodule

`default_nettype wire
